>>> rtl/sbb_pkg.sv
// sbb_pkg: shared types, constants and helpers for the stroke padded bounding box
// no dependencies; compiled first
`timescale 1ns / 1ps

package sbb_pkg;

    // coordinate width of every Q16.16 field
    localparam int COORD_BITS = 32;
    // headroom for point sums of up to three coordinates
    localparam int WIDE_BITS  = COORD_BITS + 3;
    localparam int CMD_BITS   = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;

    // drawing command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_LINE   = 3'd0,
        CMD_PATH   = 3'd1,
        CMD_RECT   = 3'd2,
        CMD_CIRCLE = 3'd3,
        CMD_IGNORE = 3'd4
    } cmd_code_t;

    // one command beat as held in the input register
    typedef struct packed {
        logic [CMD_BITS-1:0] command;
        coord_t              coord_x;
        coord_t              coord_y;
        coord_t              second_x;
        coord_t              second_y;
        coord_t              stroke_width;
        logic                last_command;
    } cmd_t;

    // axis-aligned box plus a flag that it holds at least one point
    typedef struct packed {
        logic   hit;
        coord_t min_x;
        coord_t min_y;
        coord_t max_x;
        coord_t max_y;
    } box_t;

    // sign-extend a coordinate to the wide sum width
    function automatic wide_t widen(input coord_t v);
        return wide_t'(v);
    endfunction

    function automatic coord_t min2(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t max2(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/sbb_cmd_if.sv
// sbb_cmd_if: valid/ready channel carrying one drawing command per beat
// depends on sbb_pkg
`timescale 1ns / 1ps

interface sbb_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [sbb_pkg::CMD_BITS-1:0]      command;
    logic signed [sbb_pkg::COORD_BITS-1:0] coord_x;
    logic signed [sbb_pkg::COORD_BITS-1:0] coord_y;
    logic signed [sbb_pkg::COORD_BITS-1:0] second_x;
    logic signed [sbb_pkg::COORD_BITS-1:0] second_y;
    logic signed [sbb_pkg::COORD_BITS-1:0] stroke_width;
    logic                              last_command;

    modport source (
        output valid, command, coord_x, coord_y, second_x, second_y,
               stroke_width, last_command,
        input  ready
    );

    modport sink (
        input  valid, command, coord_x, coord_y, second_x, second_y,
               stroke_width, last_command,
        output ready
    );
endinterface

>>> rtl/sbb_box_if.sv
// sbb_box_if: valid/ready channel carrying one bounding box result per beat
// depends on sbb_pkg
`timescale 1ns / 1ps

interface sbb_box_if;
    logic                              valid;
    logic                              ready;
    logic signed [sbb_pkg::COORD_BITS-1:0] box_min_x;
    logic signed [sbb_pkg::COORD_BITS-1:0] box_min_y;
    logic signed [sbb_pkg::COORD_BITS-1:0] box_max_x;
    logic signed [sbb_pkg::COORD_BITS-1:0] box_max_y;
    logic                              box_empty;

    modport source (
        output valid, box_min_x, box_min_y, box_max_x, box_max_y, box_empty,
        input  ready
    );

    modport sink (
        input  valid, box_min_x, box_min_y, box_max_x, box_max_y, box_empty,
        output ready
    );
endinterface

>>> rtl/stroke_padded_bounding_box.sv
// stroke_padded_bounding_box: top level, running padded box of drawing commands
// depends on sbb_pkg, sbb_cmd_if, sbb_box_if, sbb_cmd_box
`timescale 1ns / 1ps

// Accepts one drawing command per cycle (line, path point, rectangle, circle;
// other codes add nothing) in signed Q16.16 and grows a running axis-aligned
// box, padded by half the stroke width and saturated to the coordinate range.
// A command beat is registered, then its points are merged into the running
// box in the next cycle, so the block sustains one command per clock while no
// last command is stalled. The command flagged last produces one result beat
// (the box, or zeros with box_empty set) and clears the running box; it moves
// from the input register straight into the output register. The result sits
// in that output register; commands that are not last keep flowing while it
// waits, and only a last command stalls until the output register is free.

module stroke_padded_bounding_box (
    input  logic      clk,
    input  logic      rst_n,
    sbb_cmd_if.sink   cmd,
    sbb_box_if.source box
);

    logic           stage_valid_reg, stage_valid_next;
    sbb_pkg::cmd_t  stage_reg, stage_next;
    sbb_pkg::box_t  run_reg, run_next;
    logic           out_valid_reg, out_valid_next;
    sbb_pkg::box_t  out_reg, out_next;

    sbb_pkg::box_t  cmd_box;
    sbb_pkg::box_t  merged;
    logic           out_free;
    logic           advance;
    logic           take;

    // points of the registered command
    sbb_cmd_box u_cmd_box (
        .cmd (stage_reg),
        .box (cmd_box)
    );

    // handshake: the staged beat moves on unless it is last and the result slot is busy
    assign out_free  = !out_valid_reg || box.ready;
    assign advance   = stage_valid_reg && (!stage_reg.last_command || out_free);
    assign cmd.ready = !stage_valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    // merge command box into the running box
    always_comb
    begin
        merged = run_reg;
        if (cmd_box.hit)
        begin
            if (run_reg.hit)
            begin
                merged.min_x = sbb_pkg::min2(run_reg.min_x, cmd_box.min_x);
                merged.min_y = sbb_pkg::min2(run_reg.min_y, cmd_box.min_y);
                merged.max_x = sbb_pkg::max2(run_reg.max_x, cmd_box.max_x);
                merged.max_y = sbb_pkg::max2(run_reg.max_y, cmd_box.max_y);
            end
            else
            begin
                merged = cmd_box;
            end
        end
    end

    // input stage next state
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (take)
        begin
            stage_valid_next          = 1'b1;
            stage_next.command        = cmd.command;
            stage_next.coord_x        = cmd.coord_x;
            stage_next.coord_y        = cmd.coord_y;
            stage_next.second_x       = cmd.second_x;
            stage_next.second_y       = cmd.second_y;
            stage_next.stroke_width   = cmd.stroke_width;
            stage_next.last_command   = cmd.last_command;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // running box and result register next state
    always_comb
    begin
        run_next       = run_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (box.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            if (stage_reg.last_command)
            begin
                run_next       = '0;
                out_valid_next = 1'b1;
                out_next       = merged.hit ? merged : '0;
            end
            else
            begin
                run_next = merged;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            run_reg         <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            run_reg         <= run_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        out_reg   <= out_next;
    end

    // result beat
    assign box.valid     = out_valid_reg;
    assign box.box_min_x = out_reg.min_x;
    assign box.box_min_y = out_reg.min_y;
    assign box.box_max_x = out_reg.max_x;
    assign box.box_max_y = out_reg.max_y;
    assign box.box_empty = !out_reg.hit;

endmodule

>>> rtl/sbb_cmd_box.sv
// sbb_cmd_box: box of the points that one drawing command adds, saturated
// depends on sbb_pkg
`timescale 1ns / 1ps

module sbb_cmd_box (
    input  sbb_pkg::cmd_t cmd,
    output sbb_pkg::box_t box
);

    localparam sbb_pkg::wide_t COORD_HI =
        sbb_pkg::wide_t'((64'sd1 <<< (sbb_pkg::COORD_BITS - 1)) - 64'sd1);
    localparam sbb_pkg::wide_t COORD_LO = -COORD_HI - sbb_pkg::wide_t'(1);

    // clamp a wide point coordinate into the coordinate range
    function automatic sbb_pkg::coord_t clamp(input sbb_pkg::wide_t v);
        sbb_pkg::coord_t r;
        if (v > COORD_HI)
        begin
            r = COORD_HI[sbb_pkg::COORD_BITS-1:0];
        end
        else if (v < COORD_LO)
        begin
            r = COORD_LO[sbb_pkg::COORD_BITS-1:0];
        end
        else
        begin
            r = v[sbb_pkg::COORD_BITS-1:0];
        end
        return r;
    endfunction

    sbb_pkg::wide_t x, y, sx, sy, pad, pad_pos, rad;
    sbb_pkg::wide_t ax0, ax1, ax2, ax3;
    sbb_pkg::wide_t ay0, ay1, ay2, ay3;
    sbb_pkg::coord_t cx0, cx1, cx2, cx3;
    sbb_pkg::coord_t cy0, cy1, cy2, cy3;
    logic hit;

    // operands and padding (half width, rounded toward minus infinity)
    always_comb
    begin
        x       = sbb_pkg::widen(cmd.coord_x);
        y       = sbb_pkg::widen(cmd.coord_y);
        sx      = sbb_pkg::widen(cmd.second_x);
        sy      = sbb_pkg::widen(cmd.second_y);
        pad     = sbb_pkg::widen(cmd.stroke_width >>> 1);
        pad_pos = (pad > sbb_pkg::wide_t'(0)) ? pad : sbb_pkg::wide_t'(0);
        rad     = sx + pad;
    end

    // candidate extreme coordinates per command kind
    always_comb
    begin
        hit = 1'b1;
        ax0 = '0; ax1 = '0; ax2 = '0; ax3 = '0;
        ay0 = '0; ay1 = '0; ay2 = '0; ay3 = '0;
        case (cmd.command)
            sbb_pkg::CMD_LINE:
            begin
                ax0 = x - pad_pos;  ax1 = x + pad_pos;
                ax2 = sx - pad_pos; ax3 = sx + pad_pos;
                ay0 = y - pad_pos;  ay1 = y + pad_pos;
                ay2 = sy - pad_pos; ay3 = sy + pad_pos;
            end
            sbb_pkg::CMD_PATH:
            begin
                ax0 = x - pad_pos;  ax1 = x + pad_pos;
                ax2 = ax0;          ax3 = ax1;
                ay0 = y - pad_pos;  ay1 = y + pad_pos;
                ay2 = ay0;          ay3 = ay1;
            end
            sbb_pkg::CMD_RECT:
            begin
                ax0 = x - pad;      ax1 = x + sx + pad;
                ax2 = ax0;          ax3 = ax1;
                ay0 = y - pad;      ay1 = y + sy + pad;
                ay2 = ay0;          ay3 = ay1;
            end
            sbb_pkg::CMD_CIRCLE:
            begin
                ax0 = x - rad;      ax1 = x + rad;
                ax2 = ax0;          ax3 = ax1;
                ay0 = y - rad;      ay1 = y + rad;
                ay2 = ay0;          ay3 = ay1;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    // saturate each candidate, then reduce to min and max per axis
    always_comb
    begin
        cx0 = clamp(ax0); cx1 = clamp(ax1); cx2 = clamp(ax2); cx3 = clamp(ax3);
        cy0 = clamp(ay0); cy1 = clamp(ay1); cy2 = clamp(ay2); cy3 = clamp(ay3);
        box.hit   = hit;
        box.min_x = sbb_pkg::min2(sbb_pkg::min2(cx0, cx1), sbb_pkg::min2(cx2, cx3));
        box.max_x = sbb_pkg::max2(sbb_pkg::max2(cx0, cx1), sbb_pkg::max2(cx2, cx3));
        box.min_y = sbb_pkg::min2(sbb_pkg::min2(cy0, cy1), sbb_pkg::min2(cy2, cy3));
        box.max_y = sbb_pkg::max2(sbb_pkg::max2(cy0, cy1), sbb_pkg::max2(cy2, cy3));
    end

endmodule
